[hdl/page_reference_count_table_macros.svh]
`ifndef PAGE_REFERENCE_COUNT_TABLE_MACROS_SVH
`define PAGE_REFERENCE_COUNT_TABLE_MACROS_SVH

// same-cycle implication
`define PRCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PRCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication
`define PRCT_ASSERT_LATER2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

[hdl/prct_pkg.sv]
package prct_pkg;

  localparam int ADDR_W         = 40;
  localparam int CNT_OUT_W      = 16;
  localparam int NUM_PAGES_DEF  = 32768;
  localparam int PAGE_SHIFT_DEF = 12;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [ADDR_W-1:0] BASE_RESET = 40'h00_8000_0000;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam logic [1:0] OP_READ = 2'd0;
  localparam logic [1:0] OP_INC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;
  localparam logic [1:0] OP_REL  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ZERO  = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  typedef struct packed {
    logic clear;
    logic accept;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } sts_t;

endpackage

[hdl/page_reference_count_table.sv]
// channel   direction  word layout (low bit up)
// in_       slave      opcode[1:0], page_address[41:2], zero pad to 48
// out_      master     count[15:0], status[17:16], page_now_free[18], zero pad to 24
// cfg_      write      base_address[39:0]
//
// One item at a time: accept reads the count memory, and the update state then writes it.
// The memory has a single write port; a busy output register stalls the update state.
// After reset a clearing pass writes zero to all NUM_PAGES entries, one per cycle,
// with in_tready low; configuration writes are taken throughout.
module page_reference_count_table #(
  parameter int NUM_PAGES  = prct_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = prct_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = prct_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [prct_pkg::IN_DATA_W-1:0]  in_tdata,   // opcode, page_address
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [prct_pkg::OUT_DATA_W-1:0] out_tdata,  // count, status, page_now_free
  input  logic                            cfg_we,
  input  logic [prct_pkg::ADDR_W-1:0]     cfg_wdata   // base_address
);
  import prct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  prct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prct_dp #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[hdl/prct_ctrl.sv]
module prct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  prct_pkg::sts_t sts,
  output prct_pkg::cmd_t cmd
);
  import prct_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!sts.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hdl/prct_dp.sv]
module prct_dp #(
  parameter int NUM_PAGES  = prct_pkg::NUM_PAGES_DEF,
  parameter int PAGE_SHIFT = prct_pkg::PAGE_SHIFT_DEF,
  parameter int COUNT_BITS = prct_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [prct_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [prct_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [prct_pkg::ADDR_W-1:0]     cfg_wdata,
  input  prct_pkg::cmd_t                  cmd,
  output prct_pkg::sts_t                  sts
);
  import prct_pkg::*;

  localparam int IDX_W = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int EXT_W = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

  logic [COUNT_BITS-1:0] mem [NUM_PAGES];

  logic [ADDR_W-1:0]     base_r;
  logic [IDX_W-1:0]      clr_cnt_r;
  logic [IDX_W-1:0]      idx_r;
  logic [1:0]            op_r;
  logic                  oor_r;
  logic [COUNT_BITS-1:0] rd_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [CNT_OUT_W-1:0]  out_count_r;
  logic [1:0]            out_status_r;
  logic                  out_free_r;

  logic [1:0]            in_op;
  logic [ADDR_W-1:0]     in_addr;
  logic [ADDR_W-1:0]     rounded;
  logic [ADDR_W:0]       diff;
  logic [ADDR_W:0]       page_num;
  logic                  in_oor;
  logic [IDX_W-1:0]      in_idx;

  logic [COUNT_BITS-1:0] new_cnt;
  logic [COUNT_BITS-1:0] res_cnt;
  logic [EXT_W-1:0]      res_ext;
  logic [1:0]            res_status;
  logic                  res_free;
  logic                  upd_we;

  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [COUNT_BITS-1:0] mem_wd;

  assign in_op    = in_tdata[1:0];
  assign in_addr  = in_tdata[ADDR_W+1:2];
  assign rounded  = {in_addr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
  assign diff     = {1'b0, rounded} - {1'b0, base_r};
  assign page_num = diff >> PAGE_SHIFT;
  assign in_oor   = diff[ADDR_W] || (page_num >= (ADDR_W+1)'(NUM_PAGES));
  assign in_idx   = IDX_W'(page_num);

  always_comb begin
    new_cnt    = rd_r;
    res_cnt    = rd_r;
    res_status = ST_OK;
    res_free   = 1'b0;
    upd_we     = 1'b0;
    if (oor_r) begin
      res_cnt    = '0;
      res_status = ST_RANGE;
    end else begin
      case (op_r)
        OP_READ: begin
          res_cnt = rd_r;
        end
        OP_INC: begin
          if (rd_r == {COUNT_BITS{1'b1}}) begin
            res_status = ST_SAT;
          end else begin
            new_cnt = rd_r + COUNT_BITS'(1);
            res_cnt = new_cnt;
            upd_we  = 1'b1;
          end
        end
        OP_DEC, OP_REL: begin
          if (rd_r == '0) begin
            res_cnt    = '0;
            res_status = ST_ZERO;
          end else begin
            new_cnt  = rd_r - COUNT_BITS'(1);
            res_cnt  = new_cnt;
            upd_we   = 1'b1;
            res_free = (op_r == OP_REL) && (new_cnt == '0);
          end
        end
        default: begin
          res_cnt = rd_r;
        end
      endcase
    end
  end

  assign res_ext = EXT_W'(res_cnt);

  assign mem_we = cmd.clear || (cmd.update && upd_we);
  assign mem_wa = cmd.clear ? clr_cnt_r : idx_r;
  assign mem_wd = cmd.clear ? '0 : new_cnt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.accept) begin
      rd_r <= mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_idx;
      op_r  <= in_op;
      oor_r <= in_oor;
    end
    if (cmd.update) begin
      out_count_r  <= res_ext[CNT_OUT_W-1:0];
      out_status_r <= res_status;
      out_free_r   <= res_free;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.update) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        base_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.clear_last = (clr_cnt_r == IDX_W'(NUM_PAGES - 1));
  assign sts.out_busy   = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CNT_OUT_W-3){1'b0}}, out_free_r, out_status_r, out_count_r};

endmodule

[hdl/prct_checker.sv]
`include "page_reference_count_table_macros.svh"

module prct_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [prct_pkg::OUT_DATA_W-1:0] out_tdata
);
  import prct_pkg::*;

  `PRCT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "out word dropped while stalled")

  `PRCT_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "ready right after accept")

  `PRCT_ASSERT_LATER2(a_result_due, in_tvalid && in_tready && !out_tvalid, out_tvalid, "result late")

  `PRCT_ASSERT_NOW(a_range_zero, out_tvalid && (out_tdata[17:16] == ST_RANGE), (out_tdata[15:0] == '0) && !out_tdata[18], "range result not zero")

  `PRCT_ASSERT_NOW(a_free_ok, out_tvalid && out_tdata[18], (out_tdata[15:0] == '0) && (out_tdata[17:16] == ST_OK), "free flag with bad count")

endmodule

bind page_reference_count_table prct_checker u_prct_checker (.*);

[tb/sv/page_reference_count_table_tb.sv]
`timescale 1ns / 100ps

module page_reference_count_table_tb;
  import prct_pkg::*;

  localparam int NUM_PAGES = NUM_PAGES_DEF;
  localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
  localparam int COUNT_BITS = COUNT_BITS_DEF;
  localparam int PAD_W = IN_DATA_W - ADDR_W - 2;
  localparam int STALL_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int PROBE_ROWS = 23;
  localparam int RANDOM_PHASES = 6;
  localparam int WORDS_PER_PHASE = 175;

  typedef struct packed {
    logic                 now_free;
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] count;
  } page_result_t;

  typedef struct {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    page_result_t      want;
  } probe_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // opcode, page_address
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // count, status, page_now_free
  logic                  cfg_we = 1'b0;
  logic [ADDR_W-1:0]     cfg_wdata = '0; // base_address

  logic [COUNT_BITS-1:0] page_tally [NUM_PAGES];
  logic [ADDR_W-1:0]     tracked_base = BASE_RESET;
  page_result_t          pending_tallies[$];
  int unsigned           hot_pages [8];
  int                    in_gap_pct = 0;
  int                    out_gap_pct = 0;
  int                    mismatch_count = 0;
  int                    idle_cycles = 0;
  int                    hold_req = 0;
  int                    hold_seen = 0;
  int                    hold_left = 0;

  probe_row_t probe_rows [PROBE_ROWS] = '{
    '{OP_READ, 40'h00_8000_0000, 1'b1, '{1'b0, ST_OK,    16'd0}},
    '{OP_DEC,  40'h00_8000_0000, 1'b1, '{1'b0, ST_ZERO,  16'd0}},
    '{OP_REL,  40'h00_8000_0123, 1'b1, '{1'b0, ST_ZERO,  16'd0}},
    '{OP_INC,  40'h00_8000_0FFF, 1'b1, '{1'b0, ST_OK,    16'd1}},
    '{OP_INC,  40'h00_8000_0000, 1'b1, '{1'b0, ST_OK,    16'd2}},
    '{OP_READ, 40'h00_8000_0800, 1'b1, '{1'b0, ST_OK,    16'd2}},
    '{OP_REL,  40'h00_8000_0000, 1'b1, '{1'b0, ST_OK,    16'd1}},
    '{OP_REL,  40'h00_8000_0000, 1'b1, '{1'b1, ST_OK,    16'd0}},
    '{OP_INC,  40'h00_8000_1000, 1'b0, '0},
    '{OP_DEC,  40'h00_8000_1000, 1'b0, '0},
    '{OP_READ, 40'h00_7FFF_FFFF, 1'b1, '{1'b0, ST_RANGE, 16'd0}},
    '{OP_INC,  40'h00_0000_0000, 1'b1, '{1'b0, ST_RANGE, 16'd0}},
    '{OP_REL,  40'hFF_FFFF_FFFF, 1'b1, '{1'b0, ST_RANGE, 16'd0}},
    '{OP_INC,  40'h00_87FF_F000, 1'b1, '{1'b0, ST_OK,    16'd1}},
    '{OP_READ, 40'h00_87FF_FFFF, 1'b0, '0},
    '{OP_DEC,  40'h00_8800_0000, 1'b1, '{1'b0, ST_RANGE, 16'd0}},
    '{OP_REL,  40'h00_87FF_F000, 1'b0, '0},
    '{OP_INC,  40'h00_8555_5AAA, 1'b0, '0},
    '{OP_INC,  40'hAA_AAAA_AAAA, 1'b1, '{1'b0, ST_RANGE, 16'd0}},
    '{OP_DEC,  40'h55_5555_5555, 1'b1, '{1'b0, ST_RANGE, 16'd0}},
    '{OP_READ, 40'h00_8555_5555, 1'b0, '0},
    '{OP_DEC,  40'h00_8555_5000, 1'b0, '0},
    '{OP_REL,  40'h00_8555_5FFF, 1'b0, '0}
  };

  logic [ADDR_W-1:0] phase_bases [RANDOM_PHASES] = '{
    BASE_RESET, 40'h00_0000_0000, 40'h00_1234_5ABC,
    40'hFF_F800_0000, 40'hFF_FFFF_F000, 40'hFF_FFFF_FFFF
  };

  page_reference_count_table dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic page_result_t tally_request(logic [1:0] op, logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0]     rounded;
    logic [ADDR_W-1:0]     offset;
    logic [COUNT_BITS-1:0] c;
    int unsigned           idx;
    page_result_t          r;
    r = '{1'b0, ST_RANGE, {CNT_OUT_W{1'b0}}};
    rounded = {addr[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    if (rounded < tracked_base) return r;
    offset = (rounded - tracked_base) >> PAGE_SHIFT;
    if (offset >= NUM_PAGES) return r;
    idx = 32'(offset);
    c = page_tally[idx];
    r.status = ST_OK;
    case (op)
      OP_READ: begin
        r.count = CNT_OUT_W'(c);
      end
      OP_INC: begin
        if (c == {COUNT_BITS{1'b1}}) begin
          r.status = ST_SAT;
        end else begin
          c = c + COUNT_BITS'(1);
          page_tally[idx] = c;
        end
        r.count = CNT_OUT_W'(c);
      end
      default: begin
        if (c == '0) begin
          r.status = ST_ZERO;
        end else begin
          c = c - COUNT_BITS'(1);
          page_tally[idx] = c;
          r.count = CNT_OUT_W'(c);
          r.now_free = (op == OP_REL) && (c == '0);
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [1:0] pick_opcode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return OP_INC;
    if (r < 55) return OP_READ;
    if (r < 78) return OP_DEC;
    return OP_REL;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned sel;
    int unsigned idx;
    logic [ADDR_W-1:0] off;
    sel = $urandom_range(99);
    off = ADDR_W'($urandom_range((1 << PAGE_SHIFT) - 1));
    if (sel >= 90) return ADDR_W'({$urandom, $urandom});
    if (sel >= 85) return tracked_base - ADDR_W'($urandom_range(1, 3 << PAGE_SHIFT));
    if (sel < 65) idx = hot_pages[$urandom_range(7)];
    else if (sel < 80) idx = $urandom_range(NUM_PAGES - 1);
    else idx = NUM_PAGES + $urandom_range(2);
    return tracked_base + (ADDR_W'(idx) << PAGE_SHIFT) + off;
  endfunction

  task automatic offer_word(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                            input bit typed, input page_result_t want);
    page_result_t predicted;
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{PAD_W{1'b0}}, addr, op};
    do @(posedge clk); while (!in_tready);
    predicted = tally_request(op, addr);
    pending_tallies.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_tallies.size() != 0) @(posedge clk);
  endtask

  task automatic write_base(input logic [ADDR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracked_base = value;
  endtask

  task automatic flag_field(input string field, input int unsigned want, input int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s differs: expected %0d, got %0d", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin : check_results
    page_result_t want;
    page_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = page_result_t'(out_tdata[CNT_OUT_W+2:0]);
      if (pending_tallies.size() == 0) begin
        flag_field("unexpected word", 0, 32'(out_tdata));
      end else begin
        want = pending_tallies.pop_front();
        if (got.count !== want.count)
          flag_field("count", 32'(want.count), 32'(got.count));
        if (got.status !== want.status)
          flag_field("status", 32'(want.status), 32'(got.status));
        if (got.now_free !== want.now_free)
          flag_field("page_now_free", 32'(want.now_free), 32'(got.now_free));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int drawn;
    drawn = 0;
    foreach (page_tally[i]) page_tally[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    in_gap_pct = 27;
    out_gap_pct = 57;
    for (int i = 0; i < PROBE_ROWS; i++)
      offer_word(probe_rows[i].op, probe_rows[i].addr, probe_rows[i].typed, probe_rows[i].want);
    drain();

    // walk one page's count up, then down, and read it
    in_gap_pct = 0;
    out_gap_pct = 0;
    write_base('0);
    for (int i = 0; i < 12; i++)
      offer_word(OP_INC, ADDR_W'(32'h3000 + $urandom_range(12'hFFF)), 1'b0, '0);
    offer_word(OP_DEC, 40'h00_0000_3ABC, 1'b0, '0);
    offer_word(OP_REL, 40'h00_0000_3000, 1'b0, '0);
    offer_word(OP_READ, 40'h00_0000_3FFF, 1'b0, '0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_base(phase_bases[p]);
      hot_pages[0] = 0;
      hot_pages[1] = NUM_PAGES - 1;
      for (int h = 2; h < 8; h++) hot_pages[h] = $urandom_range(NUM_PAGES - 1);
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if (drawn < 350) begin
          in_gap_pct = 27;
          out_gap_pct = 57;
        end else if (drawn < 700) begin
          in_gap_pct = 57;
          out_gap_pct = 27;
        end else begin
          in_gap_pct = 0;
          out_gap_pct = 0;
        end
        if (drawn == 400 || drawn == 800) hold_req++;
        if (drawn == 450 || drawn == 900) drain();
        offer_word(pick_opcode(), pick_address(), 1'b0, '0);
        drawn++;
      end
      drain();
    end

    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
